// ----- sv/fird_pkg.sv -----
// shared types for the fir decimator
`timescale 1ns / 1ps

package fird_pkg;

    // sequencer states of the tap walk
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } fird_state_t;

    // control that travels beside the data read from the two memories
    typedef struct packed {
        logic vld;
        logic last;
        logic dat_ok;
        logic coef_ok;
    } fird_tap_ctrl_t;

    // register indexes on the configuration port
    localparam logic REG_DECIM = 1'b0;
    localparam logic REG_TAPS  = 1'b1;

endpackage

// ----- sv/fird_mac.sv -----
// shared complex-by-real multiply-accumulate with rounding and saturation
`timescale 1ns / 1ps

module fird_mac
    import fird_pkg::*;
#(
    parameter int NUM_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  fird_tap_ctrl_t                tap_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] tap_re,
    input  logic signed [SAMPLE_BITS-1:0] tap_im,
    input  logic signed [COEF_BITS-1:0]   tap_coef,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] res_re,
    output logic signed [SAMPLE_BITS-1:0] res_im
);

    localparam int PW = SAMPLE_BITS + COEF_BITS;
    localparam int AW = PW + $clog2(NUM_TAPS) + 1;
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
    localparam logic signed [AW-1:0] HALF_LSB = AW'(64'sd1 <<< (COEF_BITS - 2));

    logic signed [SAMPLE_BITS-1:0] op_re;
    logic signed [SAMPLE_BITS-1:0] op_im;
    logic signed [COEF_BITS-1:0]   op_c;
    logic signed [PW-1:0]          prod_re_reg, prod_re_next;
    logic signed [PW-1:0]          prod_im_reg, prod_im_next;
    logic                          mul_vld_reg, mul_last_reg;
    logic signed [AW-1:0]          acc_re_reg, acc_re_next;
    logic signed [AW-1:0]          acc_im_reg, acc_im_next;
    logic                          done_reg;

    // round half up to the sample grid, then clamp
    function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat(input logic signed [AW-1:0] a);
        logic signed [AW-1:0] r;
        logic signed [AW-1:0] q;
        r = a + HALF_LSB;
        q = r >>> (COEF_BITS - 1);
        if (q > SAT_HI) begin
            return SAT_HI[SAMPLE_BITS-1:0];
        end else if (q < SAT_LO) begin
            return SAT_LO[SAMPLE_BITS-1:0];
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    // entries never written read as zero
    assign op_re = tap_ctrl.dat_ok  ? tap_re   : '0;
    assign op_im = tap_ctrl.dat_ok  ? tap_im   : '0;
    assign op_c  = tap_ctrl.coef_ok ? tap_coef : '0;

    // products
    always_comb begin
        prod_re_next = op_re * op_c;
        prod_im_next = op_im * op_c;
    end

    // accumulate
    always_comb begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (start) begin
            acc_re_next = '0;
            acc_im_next = '0;
        end else if (mul_vld_reg) begin
            acc_re_next = acc_re_reg + {{(AW-PW){prod_re_reg[PW-1]}}, prod_re_reg};
            acc_im_next = acc_im_reg + {{(AW-PW){prod_im_reg[PW-1]}}, prod_im_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg  <= 1'b0;
            mul_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            mul_vld_reg  <= tap_ctrl.vld;
            mul_last_reg <= tap_ctrl.vld & tap_ctrl.last;
            done_reg     <= mul_vld_reg & mul_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
    end

    assign done   = done_reg;
    assign res_re = rnd_sat(acc_re_reg);
    assign res_im = rnd_sat(acc_im_reg);

endmodule

// ----- sv/fir_decimator.sv -----
// complex fir filter with real taps and integer decimation
//
// Input words arrive on the s_ stream. s_tuser is the op: 0 shifts the
// complex sample in s_tdata into the delay line, 1 writes one tap. Results
// leave on the m_ stream, one word per decim_factor samples. The two
// configuration registers (decim_factor, tap_count) sit on the APB port at
// byte addresses 0 and 4; write them only while the block is idle, as the
// block itself does not enforce it. A tap write and a sample that produces
// no output are taken in the idle state. For a sample that produces an
// output, one shared multiplier pair walks the taps, one tap per cycle,
// reading the delay-line and tap memories through their single read port,
// via read, multiply and accumulate registers, rounded into the output word.
// While that walk runs s_tready is low. A finished word waits in the output
// register; if the receiver stalls, further taps and decimated samples are
// still taken, and the next walk holds its result until the register frees.
// Reset (aresetn low, synchronous) zeroes the delay line and taps through a
// fill count and per-tap valid bits, clears the phase counter, and sets
// decim_factor to 1 and tap_count to NUM_TAPS.
`timescale 1ns / 1ps

module fir_decimator
    import fird_pkg::*;
#(
    parameter int NUM_TAPS    = 64,
    parameter int DECIM_MAX   = 16,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18,
    localparam int IW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1,
    localparam int IN_W  = ((IW + COEF_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    // coef_index, coef_value, sample_re, sample_im (from bit 0 up)
    input  logic [IN_W-1:0]  s_tdata,
    // op
    input  logic             s_tuser,
    // result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // out_re, out_im (from bit 0 up)
    output logic [OUT_W-1:0] m_tdata,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int TW = $clog2(NUM_TAPS + 1);
    localparam int DW = $clog2(DECIM_MAX + 1);
    localparam int PW = (DECIM_MAX > 1) ? $clog2(DECIM_MAX) : 1;
    localparam int XW = 2 * SAMPLE_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TAPS - 1);

    // input word fields
    logic [IW-1:0]                 coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;

    assign coef_index = s_tdata[IW-1:0];
    assign coef_value = s_tdata[IW +: COEF_BITS];
    assign sample_re  = s_tdata[IW + COEF_BITS +: SAMPLE_BITS];
    assign sample_im  = s_tdata[IW + COEF_BITS + SAMPLE_BITS +: SAMPLE_BITS];

    // memories
    logic [XW-1:0]        dmem [NUM_TAPS];
    logic [COEF_BITS-1:0] cmem [NUM_TAPS];
    logic [XW-1:0]        dq_reg;
    logic [COEF_BITS-1:0] cq_reg;

    fird_state_t    state_reg, state_next;
    logic [DW-1:0]  decim_reg;
    logic [TW-1:0]  taps_reg;
    logic [PW-1:0]  phase_reg, phase_next;
    logic [IW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [TW-1:0]  fill_reg, fill_next;
    logic [IW-1:0]  rd_addr_reg, rd_addr_next;
    logic [IW-1:0]  k_reg, k_next;
    logic [NUM_TAPS-1:0] cvalid_reg;
    fird_tap_ctrl_t rd_ctrl_reg, rd_ctrl_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    logic           in_acc, smp_acc, coef_acc, start, rd_en, out_free, mac_done, cfg_wr;
    logic [IW-1:0]  ptr_inc, taps_m1;
    logic [PW-1:0]  reload;
    logic signed [SAMPLE_BITS-1:0] res_re, res_im;

    assign in_acc   = s_tvalid & s_tready;
    assign smp_acc  = in_acc & ~s_tuser;
    assign coef_acc = in_acc & s_tuser & (32'(coef_index) < NUM_TAPS);
    assign start    = smp_acc & (phase_reg == '0);
    assign rd_en    = (state_reg == ST_RUN);
    assign out_free = ~m_tvalid_reg | m_tready;
    assign ptr_inc  = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IW'(1);
    assign cfg_wr   = psel & penable & pwrite & pready;

    // effective tap count less one
    always_comb begin
        if (taps_reg == '0) begin
            taps_m1 = '0;
        end else if (taps_reg > TW'(NUM_TAPS)) begin
            taps_m1 = LAST_IDX;
        end else begin
            taps_m1 = IW'(taps_reg - TW'(1));
        end
    end

    // decimation reload value
    always_comb begin
        if (decim_reg == '0) begin
            reload = '0;
        end else if (decim_reg > DW'(DECIM_MAX)) begin
            reload = PW'(DECIM_MAX - 1);
        end else begin
            reload = PW'(decim_reg - DW'(1));
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) state_next = ST_RUN;
            end
            ST_RUN: begin
                if (k_reg == taps_m1) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (mac_done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready      = (state_reg == ST_IDLE);
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        rd_ctrl_next  = '0;
        case (state_reg)
            ST_RUN: begin
                rd_ctrl_next.vld     = 1'b1;
                rd_ctrl_next.last    = (k_reg == taps_m1);
                rd_ctrl_next.dat_ok  = (TW'(k_reg) < fill_reg);
                rd_ctrl_next.coef_ok = cvalid_reg[k_reg];
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({res_im, res_re});
                end
            end
            default: begin
            end
        endcase
    end

    // sample bookkeeping and tap walk counters
    always_comb begin
        wr_ptr_next  = wr_ptr_reg;
        fill_next    = fill_reg;
        phase_next   = phase_reg;
        rd_addr_next = rd_addr_reg;
        k_next       = k_reg;
        if (smp_acc) begin
            wr_ptr_next = ptr_inc;
            if (fill_reg != TW'(NUM_TAPS)) fill_next = fill_reg + TW'(1);
            phase_next = (phase_reg == '0) ? reload : phase_reg - PW'(1);
        end
        if (start) begin
            rd_addr_next = ptr_inc;
            k_next       = '0;
        end else if (rd_en) begin
            rd_addr_next = (rd_addr_reg == '0) ? LAST_IDX : rd_addr_reg - IW'(1);
            k_next       = k_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            decim_reg    <= DW'(1);
            taps_reg     <= TW'(NUM_TAPS);
            phase_reg    <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            cvalid_reg   <= '0;
            rd_ctrl_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            wr_ptr_reg   <= wr_ptr_next;
            fill_reg     <= fill_next;
            rd_ctrl_reg  <= rd_ctrl_next;
            m_tvalid_reg <= m_tvalid_next;
            if (coef_acc) cvalid_reg[coef_index] <= 1'b1;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_DECIM: decim_reg <= pwdata[DW-1:0];
                    REG_TAPS:  taps_reg  <= pwdata[TW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        k_reg       <= k_next;
        m_tdata_reg <= m_tdata_next;
    end

    // delay line memory, newest sample at the write pointer
    always_ff @(posedge aclk) begin
        if (smp_acc) dmem[ptr_inc] <= {sample_im, sample_re};
        if (rd_en) dq_reg <= dmem[rd_addr_reg];
    end

    // tap memory
    always_ff @(posedge aclk) begin
        if (coef_acc) cmem[coef_index] <= coef_value;
        if (rd_en) cq_reg <= cmem[k_reg];
    end

    fird_mac #(
        .NUM_TAPS    (NUM_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .tap_ctrl (rd_ctrl_reg),
        .tap_re   (dq_reg[SAMPLE_BITS-1:0]),
        .tap_im   (dq_reg[XW-1:SAMPLE_BITS]),
        .tap_coef (cq_reg),
        .done     (mac_done),
        .res_re   (res_re),
        .res_im   (res_im)
    );

    // register readback
    always_comb begin
        case (paddr[2])
            REG_DECIM: prdata = 32'(decim_reg);
            REG_TAPS:  prdata = 32'(taps_reg);
            default:   prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
